>>> rtl/stt_pkg.sv
// Shared types, codes and lookup functions for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

   // Token type codes.
   localparam logic [4:0] TT_INT        = 5'd0;
   localparam logic [4:0] TT_OP         = 5'd1;
   localparam logic [4:0] TT_KW_BASE    = 5'd2;
   localparam logic [4:0] TT_DELIM_BASE = 5'd12;
   localparam logic [4:0] TT_IDENT      = 5'd20;

   // Held operator codes beyond the single operators 1..12.
   localparam logic [3:0] HOLD_NONE = 4'd0;
   localparam logic [3:0] HOLD_SHR  = 4'd13;
   localparam logic [3:0] HOLD_SHL  = 4'd14;
   localparam logic [3:0] HOLD_POW  = 4'd15;

   // Operator codes for the prefix-based double and triple operators.
   localparam logic [5:0] OPC_NONE     = 6'd0;
   localparam logic [5:0] OPC_SHR      = 6'd20;
   localparam logic [5:0] OPC_SHL      = 6'd22;
   localparam logic [5:0] OPC_POW      = 6'd27;
   localparam logic [5:0] OPC_SHR_ASGN = 6'd32;
   localparam logic [5:0] OPC_SHL_ASGN = 6'd33;
   localparam logic [5:0] OPC_POW_ASGN = 6'd34;

   localparam int         KW_COUNT = 10;
   localparam logic [9:0] ALL_KW   = 10'h3FF;

   localparam logic [7:0]  CH_EQ    = 8'h3D;
   localparam logic [7:0]  CH_NL    = 8'h0A;
   localparam logic [23:0] LINE_TOP = 24'hFFFFFF;

   // Depth of the result queue, in groups of up to two tokens.
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [4:0]  token_type;
      logic [5:0]  operator_code;
      logic [7:0]  symbol_char;
      logic [7:0]  word_length;
      logic [23:0] line_number;
      logic [15:0] column_number;
      logic        last_of_run;
   } tok_rec_type;

   // All tokens one byte causes; tok1 is used only when tok0 is not the last.
   typedef struct packed {
      tok_rec_type tok1;
      tok_rec_type tok0;
   } grp_type;

   function automatic tok_rec_type make_tok(input logic [4:0] ttype, input logic [5:0] opc,
                                            input logic [7:0] sym, input logic [7:0] wlen,
                                            input logic [23:0] line, input logic [15:0] col);
      tok_rec_type t;
      t.token_type    = ttype;
      t.operator_code = opc;
      t.symbol_char   = sym;
      t.word_length   = wlen;
      t.line_number   = line;
      t.column_number = col;
      t.last_of_run   = 1'b0;
      return t;
   endfunction

   function automatic logic [15:0] sat_col_add(input logic [15:0] col, input logic [1:0] k);
      logic [16:0] s;
      s = {1'b0, col} + 17'(k);
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   function automatic logic is_printable(input logic [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || (c >= 8'd32 && c <= 8'd126);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
             (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Single operator code of a character, zero if it is not an operator.
   function automatic logic [3:0] op_index(input logic [7:0] c);
      logic [3:0] r;
      case (c)
         "+":     r = 4'd1;
         "-":     r = 4'd2;
         "*":     r = 4'd3;
         "/":     r = 4'd4;
         "<":     r = 4'd5;
         ">":     r = 4'd6;
         "=":     r = 4'd7;
         "|":     r = 4'd8;
         "&":     r = 4'd9;
         "^":     r = 4'd10;
         "!":     r = 4'd11;
         "%":     r = 4'd12;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] op_char(input logic [3:0] h);
      logic [7:0] r;
      case (h)
         4'd1:    r = "+";
         4'd2:    r = "-";
         4'd3:    r = "*";
         4'd4:    r = "/";
         4'd5:    r = "<";
         4'd6:    r = ">";
         4'd7:    r = "=";
         4'd8:    r = "|";
         4'd9:    r = "&";
         4'd10:   r = "^";
         4'd11:   r = "!";
         4'd12:   r = "%";
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   // Double operator formed by repeating a single operator.
   function automatic logic [5:0] same_dbl(input logic [3:0] h);
      logic [5:0] r;
      case (h)
         4'd1:    r = 6'd15;
         4'd2:    r = 6'd13;
         4'd7:    r = 6'd17;
         4'd8:    r = 6'd25;
         4'd9:    r = 6'd23;
         default: r = OPC_NONE;
      endcase
      return r;
   endfunction

   // Repeated operators that may still grow into a triple operator.
   function automatic logic [3:0] same_hold(input logic [3:0] h);
      logic [3:0] r;
      case (h)
         4'd3:    r = HOLD_POW;
         4'd5:    r = HOLD_SHL;
         4'd6:    r = HOLD_SHR;
         default: r = HOLD_NONE;
      endcase
      return r;
   endfunction

   // Double operator formed by a single operator followed by an equals sign.
   function automatic logic [5:0] eq_dbl(input logic [3:0] h);
      logic [5:0] r;
      case (h)
         4'd1:    r = 6'd16;
         4'd2:    r = 6'd14;
         4'd3:    r = 6'd28;
         4'd4:    r = 6'd29;
         4'd5:    r = 6'd21;
         4'd6:    r = 6'd19;
         4'd7:    r = 6'd17;
         4'd8:    r = 6'd26;
         4'd9:    r = 6'd24;
         4'd10:   r = 6'd31;
         4'd11:   r = 6'd18;
         4'd12:   r = 6'd30;
         default: r = OPC_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] prefix_dbl(input logic [3:0] h);
      logic [5:0] r;
      case (h)
         HOLD_SHR: r = OPC_SHR;
         HOLD_SHL: r = OPC_SHL;
         default:  r = OPC_POW;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] prefix_tpl(input logic [3:0] h);
      logic [5:0] r;
      case (h)
         HOLD_SHR: r = OPC_SHR_ASGN;
         HOLD_SHL: r = OPC_SHL_ASGN;
         default:  r = OPC_POW_ASGN;
      endcase
      return r;
   endfunction

   // Delimiter position 1..8, zero if the character is not a delimiter.
   function automatic logic [3:0] delim_index(input logic [7:0] c);
      logic [3:0] r;
      case (c)
         ";":     r = 4'd1;
         "(":     r = 4'd2;
         ")":     r = 4'd3;
         "{":     r = 4'd4;
         "}":     r = 4'd5;
         "[":     r = 4'd6;
         "]":     r = 4'd7;
         ",":     r = 4'd8;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] kw_len(input logic [3:0] k);
      logic [2:0] r;
      case (k)
         4'd0:    r = 3'd2;
         4'd1:    r = 3'd6;
         4'd2:    r = 3'd4;
         4'd3:    r = 3'd3;
         4'd4:    r = 3'd3;
         4'd5:    r = 3'd2;
         4'd6:    r = 3'd4;
         4'd7:    r = 3'd4;
         4'd8:    r = 3'd5;
         4'd9:    r = 3'd3;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   // Keyword text, first character in the top byte, zero padded.
   function automatic logic [47:0] kw_text(input logic [3:0] k);
      logic [47:0] r;
      case (k)
         4'd0:    r = {"fn", 32'h0};
         4'd1:    r = "return";
         4'd2:    r = {"exit", 16'h0};
         4'd3:    r = {"let", 24'h0};
         4'd4:    r = {"mut", 24'h0};
         4'd5:    r = {"if", 32'h0};
         4'd6:    r = {"elif", 16'h0};
         4'd7:    r = {"else", 16'h0};
         4'd8:    r = {"while", 8'h0};
         4'd9:    r = {"for", 24'h0};
         default: r = 48'h0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] pos);
      logic [47:0] t;
      logic [7:0]  r;
      t = kw_text(k);
      case (pos)
         3'd0:    r = t[47:40];
         3'd1:    r = t[39:32];
         3'd2:    r = t[31:24];
         3'd3:    r = t[23:16];
         3'd4:    r = t[15:8];
         3'd5:    r = t[7:0];
         default: r = 8'd0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/source_text_tokenizer.sv
// A byte accepted by the tokenizer is first held in the input register of the core; the
// tokens it causes are then written into the token queue, whose head is presented.
// Throughput: one byte per cycle while the input is not stalled; each token takes one output
// beat, so a byte that ends a word and is a non-operator symbol gives two result tokens.
// The input stalls when the four-group token queue cannot take the byte in flight.
// Reset (synchronous) empties the queue and returns line and column to one.
`timescale 1ns / 1ps

module source_text_tokenizer #(
   parameter int WORD_LENGTH_LIMIT = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_type,
   output logic [5:0]  rsp_operator_code,
   output logic [7:0]  rsp_symbol_char,
   output logic [7:0]  rsp_word_length,
   output logic [23:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic        rsp_last_of_run
);
   import stt_pkg::*;

   logic        take_in;
   logic        busy;
   logic        push;
   grp_type     grp;
   logic        full;
   logic        almost_full;
   tok_rec_type head;

   // Keep room for the byte in the input register before taking another.
   assign req_stall = full || (busy && almost_full);
   assign take_in   = req_valid && !req_stall;

   stt_lexer_core #(
      .WORD_LENGTH_LIMIT(WORD_LENGTH_LIMIT)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .take_in    (take_in),
      .text_byte  (req_text_byte),
      .end_of_text(req_end_of_text),
      .busy       (busy),
      .push       (push),
      .grp        (grp)
   );

   stt_token_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .grp        (grp),
      .pop        (rsp_valid && !rsp_stall),
      .head_valid (rsp_valid),
      .head       (head),
      .full       (full),
      .almost_full(almost_full)
   );

   // Result beat fields.
   assign rsp_token_type    = head.token_type;
   assign rsp_operator_code = head.operator_code;
   assign rsp_symbol_char   = head.symbol_char;
   assign rsp_word_length   = head.word_length;
   assign rsp_line_number   = head.line_number;
   assign rsp_column_number = head.column_number;
   assign rsp_last_of_run   = head.last_of_run;

endmodule

>>> rtl/stt_lexer_core.sv
// Input register, lexer state and the single-pass token logic for one byte.
`timescale 1ns / 1ps

module stt_lexer_core #(
   parameter int WORD_LENGTH_LIMIT = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             take_in,
   input  logic [7:0]       text_byte,
   input  logic             end_of_text,
   output logic             busy,
   output logic             push,
   output stt_pkg::grp_type grp
);
   import stt_pkg::*;

   localparam int WLW = $clog2(WORD_LENGTH_LIMIT + 1);
   localparam logic [WLW-1:0] WL_TOP = WLW'(WORD_LENGTH_LIMIT);

   // Input register.
   logic       in_valid_ff;
   logic [7:0] byte_ff;
   logic       end_ff;

   // Lexer state and its next value.
   logic [23:0]    line_ff, line_in;
   logic [15:0]    col_ff, col_in;
   logic [3:0]     held_ff, held_in;
   logic [WLW-1:0] wlen_ff, wlen_in;
   logic           digits_ff, digits_in;
   logic [9:0]     cand_ff, cand_in;

   tok_rec_type toks_v [2];
   logic [1:0]  n_v;
   logic        fresh_v;
   logic [3:0]  opi_v;
   logic [3:0]  dli_v;

   // Classify a finished word.
   function automatic logic [4:0] word_class(input logic [WLW-1:0] wlen, input logic digits,
                                             input logic [9:0] cand);
      logic [4:0] r;
      logic       found;
      r     = TT_IDENT;
      found = 1'b0;
      if (digits) begin
         r = TT_INT;
      end else begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (!found && cand[k] && wlen == WLW'(kw_len(4'(k)))) begin
               r     = TT_KW_BASE + 5'(k);
               found = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Word length as reported, saturating at 255.
   function automatic logic [7:0] len_sat(input logic [WLW-1:0] wlen);
      logic [16:0] w;
      w = 17'(wlen);
      return (w > 17'd255) ? 8'hFF : w[7:0];
   endfunction

   assign busy = in_valid_ff;

   // Input beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= take_in;
      end
      if (take_in) begin
         byte_ff <= text_byte;
         end_ff  <= end_of_text;
      end
   end

   // Token logic for the registered byte, following the order of the scanner.
   always_comb begin
      line_in   = line_ff;
      col_in    = col_ff;
      held_in   = held_ff;
      wlen_in   = wlen_ff;
      digits_in = digits_ff;
      cand_in   = cand_ff;
      n_v       = 2'd0;
      fresh_v   = 1'b0;
      opi_v     = op_index(byte_ff);
      dli_v     = delim_index(byte_ff);
      toks_v[0] = make_tok(TT_INT, OPC_NONE, 8'd0, 8'd0, 24'd0, 16'd0);
      toks_v[1] = toks_v[0];

      if (in_valid_ff && is_printable(byte_ff)) begin
         fresh_v = 1'b1;
         // A held single operator may grow, complete or be released.
         if (held_ff != HOLD_NONE && held_ff < HOLD_SHR) begin
            if (op_char(held_ff) == byte_ff && same_hold(held_ff) != HOLD_NONE) begin
               held_in = same_hold(held_ff);
               fresh_v = 1'b0;
            end else if (op_char(held_ff) == byte_ff && same_dbl(held_ff) != OPC_NONE) begin
               held_in = HOLD_NONE;
               col_in  = sat_col_add(col_in, 2'd1);
               toks_v[n_v[0]] = make_tok(TT_OP, same_dbl(held_ff), 8'd0, 8'd0,
                                         line_in, col_in);
               n_v     = n_v + 2'd1;
               fresh_v = 1'b0;
            end else if (byte_ff == CH_EQ && eq_dbl(held_ff) != OPC_NONE) begin
               held_in = HOLD_NONE;
               col_in  = sat_col_add(col_in, 2'd1);
               toks_v[n_v[0]] = make_tok(TT_OP, eq_dbl(held_ff), 8'd0, 8'd0,
                                         line_in, col_in);
               n_v     = n_v + 2'd1;
               fresh_v = 1'b0;
            end else begin
               held_in = HOLD_NONE;
               toks_v[n_v[0]] = make_tok(TT_OP, 6'(held_ff), op_char(held_ff), 8'd0,
                                         line_in, col_in);
               n_v     = n_v + 2'd1;
            end
         end else if (held_ff >= HOLD_SHR) begin
            // A held prefix becomes a triple operator or is released as a double.
            held_in = HOLD_NONE;
            if (byte_ff == CH_EQ) begin
               col_in  = sat_col_add(col_in, 2'd2);
               toks_v[n_v[0]] = make_tok(TT_OP, prefix_tpl(held_ff), 8'd0, 8'd0,
                                         line_in, col_in);
               fresh_v = 1'b0;
            end else begin
               col_in  = sat_col_add(col_in, 2'd1);
               toks_v[n_v[0]] = make_tok(TT_OP, prefix_dbl(held_ff), 8'd0, 8'd0,
                                         line_in, col_in);
            end
            n_v = n_v + 2'd1;
         end

         // The byte itself, seen afresh.
         if (fresh_v) begin
            col_in = sat_col_add(col_in, 2'd1);
            if (is_word_char(byte_ff)) begin
               for (int k = 0; k < KW_COUNT; k++) begin
                  if (wlen_in >= WLW'(kw_len(4'(k))) ||
                      kw_char(4'(k), wlen_in[2:0]) != byte_ff) begin
                     cand_in[k] = 1'b0;
                  end
               end
               if (!is_digit(byte_ff)) begin
                  digits_in = 1'b0;
               end
               if (wlen_in < WL_TOP) begin
                  wlen_in = wlen_in + WLW'(1);
               end
            end else begin
               if (wlen_in != '0) begin
                  toks_v[n_v[0]] = make_tok(word_class(wlen_in, digits_in, cand_in), OPC_NONE,
                                            8'd0, len_sat(wlen_in), line_in, col_in);
                  n_v       = n_v + 2'd1;
                  wlen_in   = '0;
                  digits_in = 1'b1;
                  cand_in   = ALL_KW;
               end
               if (is_space(byte_ff)) begin
                  if (byte_ff == CH_NL) begin
                     if (line_in != LINE_TOP) begin
                        line_in = line_in + 24'd1;
                     end
                     col_in = 16'd0;
                  end
               end else if (opi_v != 4'd0) begin
                  held_in = opi_v;
               end else if (n_v != 2'd2) begin
                  if (dli_v != 4'd0) begin
                     toks_v[n_v[0]] = make_tok(TT_DELIM_BASE + 5'(dli_v) - 5'd1, OPC_NONE,
                                               byte_ff, 8'd0, line_in, col_in);
                  end else begin
                     toks_v[n_v[0]] = make_tok(TT_IDENT, OPC_NONE, byte_ff, 8'd0,
                                               line_in, col_in);
                  end
                  n_v = n_v + 2'd1;
               end
            end
         end
      end

      // End of text: release a held operator, then flush an open word.
      if (in_valid_ff && end_ff) begin
         if (held_in != HOLD_NONE && n_v != 2'd2) begin
            if (held_in < HOLD_SHR) begin
               toks_v[n_v[0]] = make_tok(TT_OP, 6'(held_in), op_char(held_in), 8'd0,
                                         line_in, col_in);
            end else begin
               col_in = sat_col_add(col_in, 2'd1);
               toks_v[n_v[0]] = make_tok(TT_OP, prefix_dbl(held_in), 8'd0, 8'd0,
                                         line_in, col_in);
            end
            n_v = n_v + 2'd1;
         end
         held_in = HOLD_NONE;
         if (wlen_in != '0) begin
            if (n_v != 2'd2) begin
               toks_v[n_v[0]] = make_tok(word_class(wlen_in, digits_in, cand_in), OPC_NONE,
                                         8'd0, len_sat(wlen_in), line_in, col_in);
               n_v = n_v + 2'd1;
            end
            wlen_in   = '0;
            digits_in = 1'b1;
            cand_in   = ALL_KW;
         end
      end

      // Mark the last token of this byte.
      toks_v[0].last_of_run = (n_v == 2'd1);
      toks_v[1].last_of_run = 1'b1;
   end

   assign push     = in_valid_ff && (n_v != 2'd0);
   assign grp.tok0 = toks_v[0];
   assign grp.tok1 = toks_v[1];

   // Lexer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff   <= 24'd1;
         col_ff    <= 16'd1;
         held_ff   <= HOLD_NONE;
         wlen_ff   <= '0;
         digits_ff <= 1'b1;
         cand_ff   <= ALL_KW;
      end else if (in_valid_ff) begin
         line_ff   <= line_in;
         col_ff    <= col_in;
         held_ff   <= held_in;
         wlen_ff   <= wlen_in;
         digits_ff <= digits_in;
         cand_ff   <= cand_in;
      end
   end

endmodule

>>> rtl/stt_token_queue.sv
// Queue of token groups that hands out one token per output beat.
`timescale 1ns / 1ps

module stt_token_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  stt_pkg::grp_type     grp,
   input  logic                 pop,
   output logic                 head_valid,
   output stt_pkg::tok_rec_type head,
   output logic                 full,
   output logic                 almost_full
);
   import stt_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   grp_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff;
   logic [PW-1:0] rd_ff;
   logic [LW-1:0] level_ff;
   logic          sub_ff;
   logic          pop_grp;

   assign head_valid  = level_ff != '0;
   assign head        = sub_ff ? mem_ff[rd_ff].tok1 : mem_ff[rd_ff].tok0;
   assign full        = level_ff == LW'(QUEUE_DEPTH);
   assign almost_full = level_ff == LW'(QUEUE_DEPTH - 1);
   assign pop_grp     = pop && head.last_of_run;

   // Group storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= grp;
      end
   end

   // Pointers, fill level and position inside the head group.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
         sub_ff   <= 1'b0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + PW'(1);
         end
         if (pop_grp) begin
            rd_ff  <= rd_ff + PW'(1);
            sub_ff <= 1'b0;
         end else if (pop) begin
            sub_ff <= 1'b1;
         end
         if (push && !pop_grp) begin
            level_ff <= level_ff + LW'(1);
         end else if (pop_grp && !push) begin
            level_ff <= level_ff - LW'(1);
         end
      end
   end

endmodule

>>> rtl/stt_checker.sv
// Port-level checks for the tokenizer and their binding to the top level.
`timescale 1ns / 1ps

module stt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_text_byte,
   input logic        req_end_of_text,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_token_type,
   input logic [5:0]  rsp_operator_code,
   input logic [7:0]  rsp_symbol_char,
   input logic [7:0]  rsp_word_length,
   input logic [23:0] rsp_line_number,
   input logic [15:0] rsp_column_number,
   input logic        rsp_last_of_run
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_type) &&
      $stable(rsp_operator_code) && $stable(rsp_symbol_char) &&
      $stable(rsp_word_length) && $stable(rsp_line_number) &&
      $stable(rsp_column_number) && $stable(rsp_last_of_run))
      else $error("stalled result beat changed");

   // Reset leaves no token pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Only operator tokens carry an operator code.
   a_op_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_token_type == 5'd1) == (rsp_operator_code != 6'd0)))
      else $error("operator code does not match token type");

   // A token is either a word or a symbol, never both.
   a_word_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word_length != 8'd0 && rsp_symbol_char != 8'd0))
      else $error("token has both a length and a symbol");

   // Line counting starts at one and never wraps to zero; token types stay at or below the identifier code.
   a_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_number != 24'd0 && rsp_token_type <= 5'd20)
      else $error("line number or token type out of range");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for the source text tokenizer: random and directed bytes in.
`timescale 1ns / 1ps

module tb_top;
   import stt_pkg::*;

   localparam int MAX_RUN        = 2;      // most tokens one byte can cause
   localparam int WORD_LIMIT     = 255;
   localparam int OP_COUNT       = 34;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 200;
   localparam int RANDOM_ITEMS   = 350;
   localparam int QUIET_TAIL     = 80;

   // Predicts the token stream from the bytes the tokenizer accepts and checks what comes out.
   class tokenizer_scoreboard;
      string       kw_words[KW_COUNT];
      string       op_spell[OP_COUNT + 1];
      string       delims;
      tok_rec_type expected_tokens[$];
      tok_rec_type run_toks[MAX_RUN];
      int          run_count;
      int          errors;
      logic [23:0] line_now;
      logic [15:0] col_cnt;
      string       held;
      int          word_len;
      bit          word_digits;
      logic [9:0]  kw_alive;

      function new();
         kw_words = '{"fn", "return", "exit", "let", "mut", "if", "elif", "else", "while", "for"};
         // Index in this list is the operator code.
         op_spell = '{"", "+", "-", "*", "/", "<", ">", "=", "|", "&", "^", "!", "%",
                      "--", "-=", "++", "+=", "==", "!=", ">=", ">>", "<=", "<<", "&&", "&=",
                      "||", "|=", "**", "*=", "/=", "%=", "^=", ">>=", "<<=", "**="};
         delims   = ";(){}[],";
         line_now = 24'd1;
         col_cnt  = 16'd1;
         held     = "";
         errors   = 0;
         clear_word();
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      function logic [5:0] spelled_code(string s);
         for (int i = 1; i <= OP_COUNT; i++)
            if (op_spell[i] == s) return 6'(i);
         return OPC_NONE;
      endfunction

      function void col_add(int k);
         logic [16:0] sum;
         sum = {1'b0, col_cnt} + 17'(k);
         col_cnt = sum[16] ? 16'hFFFF : sum[15:0];
      endfunction

      function void emit(logic [4:0] kind, logic [5:0] opc, logic [7:0] sym, logic [7:0] wlen);
         if (run_count >= MAX_RUN) return;
         run_toks[run_count] = '{kind, opc, sym, wlen, line_now, col_cnt, 1'b0};
         run_count++;
      endfunction

      function void clear_word();
         word_len    = 0;
         word_digits = 1'b1;
         kw_alive    = ALL_KW;
      endfunction

      // Narrow the keyword candidates with each new character of the word.
      function void add_word_char(logic [7:0] c);
         for (int k = 0; k < KW_COUNT; k++)
            if (kw_alive[k] && (word_len >= kw_words[k].len() || kw_words[k][word_len] != c))
               kw_alive[k] = 1'b0;
         if (!(c >= "0" && c <= "9")) word_digits = 1'b0;
         if (word_len < WORD_LIMIT) word_len++;
      endfunction

      function void flush_word();
         logic [4:0] kind;
         if (word_len == 0) return;
         kind = TT_IDENT;
         if (word_digits) begin
            kind = TT_INT;
         end else begin
            for (int k = KW_COUNT - 1; k >= 0; k--)
               if (kw_alive[k] && word_len == kw_words[k].len()) kind = TT_KW_BASE + 5'(k);
         end
         emit(kind, OPC_NONE, 8'd0, word_len > 255 ? 8'd255 : 8'(word_len));
         clear_word();
      endfunction

      // A held single operator goes out as is; a held prefix goes out as its double form.
      function void release_held();
         if (held.len() == 1) begin
            emit(TT_OP, spelled_code(held), held[0], 8'd0);
         end else if (held.len() == 2) begin
            col_add(1);
            emit(TT_OP, spelled_code(held), 8'd0, 8'd0);
         end
         held = "";
      endfunction

      function void handle_fresh(logic [7:0] c);
         string one;
         one = $sformatf("%c", c);
         col_add(1);
         if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             c == "_") begin
            add_word_char(c);
            return;
         end
         flush_word();
         if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            if (c == CH_NL) begin
               if (line_now != LINE_TOP) line_now++;
               col_cnt = 16'd0;
            end
            return;
         end
         if (spelled_code(one) != OPC_NONE) begin
            held = one;
            return;
         end
         for (int i = 0; i < delims.len(); i++) begin
            if (c == delims[i]) begin
               emit(TT_DELIM_BASE + 5'(i), OPC_NONE, c, 8'd0);
               return;
            end
         end
         emit(TT_IDENT, OPC_NONE, c, 8'd0);
      endfunction

      // Maximal munch: try to extend a held operator before handling the byte on its own.
      function void take_char(logic [7:0] c);
         string pair;
         if (held.len() == 1) begin
            pair = $sformatf("%s%c", held, c);
            if (spelled_code({pair, "="}) != OPC_NONE) begin
               held = pair;
               return;
            end
            if (spelled_code(pair) != OPC_NONE) begin
               held = "";
               col_add(1);
               emit(TT_OP, spelled_code(pair), 8'd0, 8'd0);
               return;
            end
            release_held();
         end else if (held.len() == 2) begin
            if (c == CH_EQ) begin
               pair = {held, "="};
               held = "";
               col_add(2);
               emit(TT_OP, spelled_code(pair), 8'd0, 8'd0);
               return;
            end
            release_held();
         end
         handle_fresh(c);
      endfunction

      // Note one accepted byte and queue the tokens it causes.
      function void note_byte(logic [7:0] c, logic eot);
         tok_rec_type t;
         run_count = 0;
         if ((c >= 8'd9 && c <= 8'd13) || (c >= 8'd32 && c <= 8'd126)) take_char(c);
         if (eot) begin
            release_held();
            flush_word();
         end
         for (int i = 0; i < run_count; i++) begin
            t = run_toks[i];
            t.last_of_run = (i == run_count - 1);
            expected_tokens.insert(expected_tokens.size(), t);
         end
      endfunction

      function void compare_field(string name, logic [23:0] want, logic [23:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
         end
      endfunction

      // Check one token beat against the oldest prediction.
      function void check_token(tok_rec_type got);
         tok_rec_type want;
         if (expected_tokens.size() == 0) begin
            $error("unexpected token: type %0d, operator %0d", got.token_type, got.operator_code);
            errors++;
            return;
         end
         want = expected_tokens.pop_front();
         compare_field("token_type", want.token_type, got.token_type);
         compare_field("operator_code", want.operator_code, got.operator_code);
         compare_field("symbol_char", want.symbol_char, got.symbol_char);
         compare_field("word_length", want.word_length, got.word_length);
         compare_field("line_number", want.line_number, got.line_number);
         compare_field("column_number", want.column_number, got.column_number);
         compare_field("last_of_run", want.last_of_run, got.last_of_run);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'd0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_token_type;
   logic [5:0]  rsp_operator_code;
   logic [7:0]  rsp_symbol_char;
   logic [7:0]  rsp_word_length;
   logic [23:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   logic        rsp_last_of_run;

   bit tx_idle_on = 1'b1;
   bit tx_calm = 1'b0;
   bit rx_idle_on = 1'b1;
   bit long_hold_req = 1'b0;
   int random_items;

   tokenizer_scoreboard sb = new();

   source_text_tokenizer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_type    (rsp_token_type),
      .rsp_operator_code (rsp_operator_code),
      .rsp_symbol_char   (rsp_symbol_char),
      .rsp_word_length   (rsp_word_length),
      .rsp_line_number   (rsp_line_number),
      .rsp_column_number (rsp_column_number),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // Clock generation.
   initial begin
      forever #4 clock = ~clock;
   end

   // Present one byte and hold it until the tokenizer takes the beat.
   task automatic send_byte(input logic [7:0] b, input logic eot);
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_byte(b, eot);
   endtask

   // Same as send_byte, but the sender may first go idle for a burst.
   task automatic offer(input logic [7:0] b, input logic eot);
      if (tx_idle_on && !tx_calm && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      send_byte(b, eot);
   endtask

   task automatic send_text(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++) offer(s[i], end_last && i == s.len() - 1);
   endtask

   // Stop sending and wait until every predicted token has come out.
   task automatic wait_for_tokens();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_word_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 10) return 8'("0" + r);
      if (r < 36) return 8'("a" + r - 10);
      if (r < 62) return 8'("A" + r - 36);
      return "_";
   endfunction

   function automatic logic random_end();
      return $urandom_range(0, 79) == 0;
   endfunction

   // One random lexical fragment: keyword, name, number, operator, delimiter, blank or noise.
   task automatic send_fragment();
      string s;
      int    pick;
      int    n;
      s = "";
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         s = sb.kw_words[$urandom_range(0, KW_COUNT - 1)];
         n = $urandom_range(0, 3);
         if (n == 0) s = {s, $sformatf("%c", random_word_char())};
         else if (n == 1) s = s.substr(0, s.len() - 2);
      end else if (pick < 35) begin
         n = $urandom_range(1, 8);
         repeat (n) s = {s, $sformatf("%c", random_word_char())};
      end else if (pick < 45) begin
         n = $urandom_range(1, 6);
         repeat (n) s = {s, $sformatf("%c", 8'("0" + $urandom_range(0, 9)))};
      end else if (pick < 70) begin
         s = sb.op_spell[$urandom_range(1, OP_COUNT)];
      end else if (pick < 78) begin
         s = $sformatf("%c", sb.delims[$urandom_range(0, sb.delims.len() - 1)]);
      end else if (pick < 88) begin
         n = $urandom_range(0, 5);
         offer(n == 5 ? " " : 8'(9 + n), random_end());
         random_items++;
      end else if (pick < 96) begin
         offer(8'($urandom), random_end());
      end else if (pick < 99) begin
         s = "#.:?@~$`'\"\\";
         s = $sformatf("%c", s[$urandom_range(0, s.len() - 1)]);
      end else begin
         n = $urandom_range(20, 60);
         repeat (n) s = {s, $sformatf("%c", random_word_char())};
      end
      for (int i = 0; i < s.len(); i++) offer(s[i], random_end());
      random_items += s.len();
   endtask

   // Receiver: random stall bursts, calm stretches, and one long hold-off on request.
   initial begin : receiver
      int burst;
      bit calm;
      calm = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 199) == 0) calm = !calm;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_idle_on && !calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Token checking and a watchdog on cycles without any accepted beat.
   initial begin : monitor
      tok_rec_type got;
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
               got.token_type    = rsp_token_type;
               got.operator_code = rsp_operator_code;
               got.symbol_char   = rsp_symbol_char;
               got.word_length   = rsp_word_length;
               got.line_number   = rsp_line_number;
               got.column_number = rsp_column_number;
               got.last_of_run   = rsp_last_of_run;
               sb.check_token(got);
               quiet_cycles = 0;
            end else if (req_valid && req_stall === 1'b0) begin
               quiet_cycles = 0;
            end else begin
               quiet_cycles++;
            end
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus and final verdict.
   initial begin : stimulus
      string s;
      bit    hold_done;
      bit    drain_done;
      hold_done  = 1'b0;
      drain_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Broken and completed prefixes, ignored bytes, and flushes at end of text.
      send_text("if(a>>b)", 1'b0);
      offer(8'h00, 1'b0);
      offer(8'hFF, 1'b0);
      send_text("{x**=9;}", 1'b0);
      send_text("y<<", 1'b1);
      send_text("z9", 1'b1);
      send_text("q+", 1'b0);
      offer(8'h80, 1'b1);

      // A word longer than the length limit, flushed by end of text.
      s = "";
      repeat ($urandom_range(256, 300)) s = {s, $sformatf("%c", random_word_char())};
      send_text(s, 1'b1);

      send_text("a>>=b;c!\n", 1'b0);

      // Random part, with one long receiver hold-off and one full drain along the way.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
         if (!hold_done && random_items >= 120) begin
            hold_done = 1'b1;
            long_hold_req = 1'b1;
            repeat (60) send_byte(";", 1'b0);
         end
         if (!drain_done && random_items >= 230) begin
            drain_done = 1'b1;
            wait_for_tokens();
         end
         if (random_items >= RANDOM_ITEMS - QUIET_TAIL) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end
         send_fragment();
      end

      wait_for_tokens();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/stt_pkg.sv
rtl/stt_lexer_core.sv
rtl/stt_token_queue.sv
rtl/source_text_tokenizer.sv
rtl/stt_checker.sv
dv/tb_top.sv
